/* rtl/apdu_command_framer_top_macros.svh */
// Assertion macros shared by the framer's checking code.
`ifndef APDU_COMMAND_FRAMER_TOP_MACROS_SVH
`define APDU_COMMAND_FRAMER_TOP_MACROS_SVH

// Check that holds only outside reset.
`define ACF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that must also hold across reset.
`define ACF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/acf_pkg.sv */
package acf_pkg;

  // Default depth of the job queue between front and back.
  localparam int unsigned ACF_QUEUE_DEPTH = 4;

  // Most bytes one input word can produce (extended header).
  localparam int unsigned ACF_MAX_BYTES = 7;

  // Input word kinds.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // ISO 7816-4 command cases.
  localparam logic [2:0] CASE_1       = 3'd0;
  localparam logic [2:0] CASE_2S      = 3'd1;
  localparam logic [2:0] CASE_2E      = 3'd2;
  localparam logic [2:0] CASE_3S      = 3'd3;
  localparam logic [2:0] CASE_3E      = 3'd4;
  localparam logic [2:0] CASE_4S      = 3'd5;
  localparam logic [2:0] CASE_4E      = 3'd6;
  localparam logic [2:0] CASE_INVALID = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_BAD_CASE  = 2'd2;
  localparam logic [1:0] ST_NO_CMD    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_SEND_SHORT = 2'd0;
  localparam logic [1:0] REG_MAX_SEND_EXT   = 2'd1;
  localparam logic [1:0] REG_MAX_RECV_SHORT = 2'd2;
  localparam logic [1:0] REG_MAX_RECV_EXT   = 2'd3;

  // One classified input word: the bytes it emits and how to flag the last one.
  typedef struct packed {
    logic [ACF_MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                    count;
    logic                          fin;
    logic [1:0]                    status;
    logic [16:0]                   total;
  } acf_job_t;

endpackage

/* rtl/apdu_command_framer_top.sv */
// ISO 7816-4 command APDU framer. A start word (tuser 0) carries the case,
// CLA, INS, P1, P2, Lc and Le; if the lengths pass the configured limits the
// block sends the header with a short or 00 hi lo extended Lc or Le, then
// passes exactly Lc data words (tuser 1) and appends the short or extended
// Le. Each output word is one frame byte; tlast marks the final byte, which
// also carries the total frame length. A limit violation, an unknown case,
// or data with no open command gives one output word with nonzero status
// and tlast. Input is taken at one word per cycle while the job queue
// (QueueDepth entries) has room. The output side emits one byte per cycle
// while out_tready is high, so an accepted start word yields 4 to 7 bytes,
// a rejected word 1, and a data word 1 to 3; sustained throughput is set
// by that serializer. Limit registers reset to 255, 65535, 256 and 65535.
`include "apdu_command_framer_top_macros.svh"

module apdu_command_framer_top #(
  parameter int unsigned QueueDepth = acf_pkg::ACF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // iso_case, class_byte, instruction_byte, param_one, param_two,
  // command_length, expected_length, data_byte, zero fill
  input  logic [79:0] in_tdata,
  // op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte, frame_length, zero fill
  output logic [31:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import acf_pkg::*;

  acf_job_t    new_job;
  acf_job_t    head_job;
  logic        accept;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic [7:0]  out_byte;
  logic [16:0] frame_length;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  acf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .accept           (accept),
    .op               (in_tuser),
    .iso_case         (in_tdata[2:0]),
    .class_byte       (in_tdata[10:3]),
    .instruction_byte (in_tdata[18:11]),
    .param_one        (in_tdata[26:19]),
    .param_two        (in_tdata[34:27]),
    .command_length   (in_tdata[50:35]),
    .expected_length  (in_tdata[66:51]),
    .data_byte        (in_tdata[74:67]),
    .job              (new_job)
  );

  acf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_job  (new_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_job)
  );

  acf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head_job),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_last   (out_tlast),
    .out_status (out_tuser),
    .out_length (frame_length)
  );

  assign out_tdata = {7'd0, frame_length, out_byte};

  // Nothing is presented right after a reset cycle.
  `ACF_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_tvalid, "output valid after reset")

  // Error words end the frame and carry no byte and no length.
  `ACF_ASSERT(a_error_shape,
              out_tvalid && out_tuser != ST_OK |-> out_tlast && out_tdata == 32'd0,
              "malformed error word")

  // Frame length appears only on the final byte.
  `ACF_ASSERT(a_length_on_last,
              out_tvalid && !out_tlast |-> out_tdata[24:8] == 17'd0,
              "frame length before last byte")

endmodule

/* rtl/acf_front.sv */
module acf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [15:0]       cfg_wdata,
  input  logic              accept,
  input  logic              op,
  input  logic [2:0]        iso_case,
  input  logic [7:0]        class_byte,
  input  logic [7:0]        instruction_byte,
  input  logic [7:0]        param_one,
  input  logic [7:0]        param_two,
  input  logic [15:0]       command_length,
  input  logic [15:0]       expected_length,
  input  logic [7:0]        data_byte,
  output acf_pkg::acf_job_t job
);
  import acf_pkg::*;

  // Limit registers.
  logic [7:0]  max_send_short_r;
  logic [15:0] max_send_ext_r;
  logic [8:0]  max_recv_short_r;
  logic [15:0] max_recv_ext_r;

  // Open command state.
  logic        open_r, open_nxt;
  logic [2:0]  case_r, case_nxt;
  logic [15:0] le_r, le_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] total_r, total_nxt;

  logic        has_data;
  logic        bad;
  logic [2:0]  hdr_len;
  logic [1:0]  trl_len;
  logic [16:0] start_total;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_send_short_r <= 8'hFF;
      max_send_ext_r   <= 16'hFFFF;
      max_recv_short_r <= 9'd256;
      max_recv_ext_r   <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_SEND_SHORT: max_send_short_r <= cfg_wdata[7:0];
        REG_MAX_SEND_EXT:   max_send_ext_r   <= cfg_wdata;
        REG_MAX_RECV_SHORT: max_recv_short_r <= cfg_wdata[8:0];
        REG_MAX_RECV_EXT:   max_recv_ext_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Length checks and frame length of a start word.
  always_comb begin
    has_data = (iso_case >= CASE_3S) && (iso_case != CASE_INVALID);
    bad = 1'b0;
    if (iso_case == CASE_2S || iso_case == CASE_4S)
      bad = bad || (expected_length > {7'd0, max_recv_short_r});
    if (iso_case == CASE_2E || iso_case == CASE_4E)
      bad = bad || (expected_length > max_recv_ext_r);
    if (iso_case == CASE_3S || iso_case == CASE_4S)
      bad = bad || (command_length > {8'd0, max_send_short_r})
                || (command_length > 16'd255);
    if (iso_case == CASE_3E || iso_case == CASE_4E)
      bad = bad || (command_length > max_send_ext_r);
    if (has_data && command_length == 16'd0)
      bad = 1'b1;

    case (iso_case)
      CASE_2S, CASE_3S, CASE_4S: hdr_len = 3'd5;
      CASE_2E, CASE_3E, CASE_4E: hdr_len = 3'd7;
      default:                   hdr_len = 3'd4;
    endcase
    case (iso_case)
      CASE_4S: trl_len = 2'd1;
      CASE_4E: trl_len = 2'd2;
      default: trl_len = 2'd0;
    endcase
    start_total = 17'(hdr_len) + 17'(trl_len)
                + (has_data ? {1'b0, command_length} : 17'd0);
  end

  // Classify the word into the bytes it produces and the next command state.
  always_comb begin
    open_nxt   = open_r;
    case_nxt   = case_r;
    le_nxt     = le_r;
    rem_nxt    = rem_r;
    total_nxt  = total_r;
    job.bytes  = '0;
    job.count  = 3'd1;
    job.fin    = 1'b0;
    job.status = ST_OK;
    job.total  = total_r;

    if (op == OP_DATA) begin
      if (!open_r || rem_r == 16'd0) begin
        job.fin    = 1'b1;
        job.status = ST_NO_CMD;
        job.total  = 17'd0;
        open_nxt   = 1'b0;
        rem_nxt    = 16'd0;
      end else begin
        rem_nxt      = rem_r - 16'd1;
        job.bytes[0] = data_byte;
        if (rem_r == 16'd1) begin
          // Final data byte: close the command and append any Le trailer.
          open_nxt = 1'b0;
          job.fin  = 1'b1;
          case (case_r)
            CASE_4S: begin
              job.bytes[1] = le_r[7:0];
              job.count    = 3'd2;
            end
            CASE_4E: begin
              job.bytes[1] = le_r[15:8];
              job.bytes[2] = le_r[7:0];
              job.count    = 3'd3;
            end
            default: ;
          endcase
        end
      end
    end else begin
      // A start word always drops whatever command was open.
      open_nxt = 1'b0;
      rem_nxt  = 16'd0;
      if (iso_case == CASE_INVALID) begin
        job.fin    = 1'b1;
        job.status = ST_BAD_CASE;
        job.total  = 17'd0;
      end else if (bad) begin
        job.fin    = 1'b1;
        job.status = ST_LIMIT;
        job.total  = 17'd0;
      end else begin
        job.bytes[0] = class_byte;
        job.bytes[1] = instruction_byte;
        job.bytes[2] = param_one;
        job.bytes[3] = param_two;
        job.count    = 3'd4;
        job.total    = start_total;
        case (iso_case)
          CASE_1: job.fin = 1'b1;
          CASE_2S: begin
            job.bytes[4] = expected_length[7:0];
            job.count    = 3'd5;
            job.fin      = 1'b1;
          end
          CASE_2E: begin
            job.bytes[5] = expected_length[15:8];
            job.bytes[6] = expected_length[7:0];
            job.count    = 3'd7;
            job.fin      = 1'b1;
          end
          CASE_3S, CASE_4S: begin
            job.bytes[4] = command_length[7:0];
            job.count    = 3'd5;
          end
          default: begin
            job.bytes[5] = command_length[15:8];
            job.bytes[6] = command_length[7:0];
            job.count    = 3'd7;
          end
        endcase
        if (has_data) begin
          open_nxt  = 1'b1;
          case_nxt  = iso_case;
          le_nxt    = expected_length;
          rem_nxt   = command_length;
          total_nxt = start_total;
        end
      end
    end
  end

  // State advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      case_r  <= CASE_1;
      le_r    <= 16'd0;
      rem_r   <= 16'd0;
      total_r <= 17'd0;
    end else if (accept) begin
      open_r  <= open_nxt;
      case_r  <= case_nxt;
      le_r    <= le_nxt;
      rem_r   <= rem_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

/* rtl/acf_queue.sv */
module acf_queue #(
  parameter int unsigned Depth = acf_pkg::ACF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  acf_pkg::acf_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output acf_pkg::acf_job_t head
);
  import acf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  acf_job_t            slot_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Pointer wrap works for any depth, not only powers of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    if (push && !pop)
      count_nxt = count_r + CntW'(1);
    else if (pop && !push)
      count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (push)
      slot_r[wr_ptr_r] <= push_job;
  end

endmodule

/* rtl/acf_back.sv */
module acf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  acf_pkg::acf_job_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [1:0]        out_status,
  output logic [16:0]       out_length
);
  import acf_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [1:0]  status_r;
  logic [16:0] length_r;
  logic        load;
  logic        final_byte;

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_status = status_r;
  assign out_length = length_r;

  // Move one head-job byte per cycle into the output register while it is free.
  assign load       = head_valid && (!valid_r || out_ready);
  assign final_byte = (idx_r == head.count - 3'd1);
  assign pop        = load && final_byte;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = final_byte ? 3'd0 : idx_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head.bytes[idx_r];
      last_r   <= final_byte && head.fin;
      status_r <= head.status;
      length_r <= (final_byte && head.fin && head.status == ST_OK) ? head.total : 17'd0;
    end
  end

endmodule
